// ===== hdl/pem_pkg.sv =====
// shared constants and types for the power and energy monitor
`default_nettype none

package pem_pkg;

  // serial multiplier: one multiplier bit per cycle
  localparam int MUL_W     = 24;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int MUL_CNT_W = 5;
  localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_W - 1);

  // serial restoring divider: one quotient bit per cycle
  localparam int DVD_W     = 64;
  localparam int DVS_W     = 32;
  localparam int DIV_CNT_W = 7;

  // divisors: mW from mV*uA, uWh from mW*us, uAh from uA*us
  localparam logic [DVS_W-1:0] MW_DIV  = 32'd1000000;
  localparam logic [DVS_W-1:0] UWH_DIV = 32'd3600000;
  localparam logic [DVS_W-1:0] UAH_DIV = 32'd3600000000;

  // quotient bits that can be nonzero for each division
  localparam logic [DIV_CNT_W-1:0] MW_STEPS  = 7'd21;
  localparam logic [DIV_CNT_W-1:0] UWH_STEPS = 7'd43;
  localparam logic [DIV_CNT_W-1:0] UAH_STEPS = 7'd33;

  // energy output clamp to 42-bit signed
  localparam logic [42:0] E_MAG_LIMIT = 43'h200_0000_0000;
  localparam logic [41:0] E_POS_MAX   = 42'h1FF_FFFF_FFFF;
  localparam logic [41:0] E_NEG_MIN   = 42'h200_0000_0000;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ===== hdl/power_energy_monitor.sv =====
// power and energy monitor top level: sequencer, statistics and stream ports
// each sample passes through the serial units and reaches m_axis_tvalid when the output is free;
// a new sample is taken only after the last one has left the serial units, which run in sequence:
//   24-step multiply, 21-step divide for mW, 24-step multiply, 43-step divide for uWh
// the next sample is taken while a finished result waits on the output register
// reset: rst is synchronous, active high; it clears all statistics, the accumulators,
//   the contract voltage and the output valid
`default_nettype none

module power_energy_monitor import pem_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // elapsed_us[23:0], voltage_mv[40:24], current_ua[64:41], zero pad [71:65]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,
  // power_mw[20:0], min_voltage[37:21], max_voltage[54:38], min_current[78:55],
  // max_current[102:79], min_power[123:103], max_power[144:124],
  // energy_uwh[186:145], charge_uah[219:187], worst_deviation[236:220],
  // sample_count[268:237], zero pad [271:269]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [271:0] m_axis_tdata,
  // contract voltage register write
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MULP = 7'b0000010,
    S_DIVP = 7'b0000100,
    S_MULE = 7'b0001000,
    S_EACC = 7'b0010000,
    S_DIVE = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // input fields
  logic [23:0] dt_in;
  logic [16:0] mv_in;
  logic [23:0] ua_in;
  logic [16:0] mv_in_mag;
  logic [23:0] ua_in_mag;
  logic        accept;

  // latched sample and intermediate results
  logic [23:0]        dt;
  logic signed [16:0] mv;
  logic signed [23:0] ua;
  logic signed [20:0] mw;
  logic               pneg;
  logic               e_neg;
  logic               c_neg;

  // statistics state
  logic [15:0]        contract;
  logic signed [16:0] volt_low, volt_high;
  logic signed [23:0] amp_low, amp_high;
  logic signed [20:0] watt_low, watt_high;
  logic [63:0]        energy_acc, charge_acc;
  logic [16:0]        deviation_peak;
  logic [31:0]        samples_seen;

  // next values of the statistics
  logic               first;
  logic signed [16:0] volt_low_next, volt_high_next;
  logic signed [23:0] amp_low_next, amp_high_next;
  logic signed [20:0] watt_low_next, watt_high_next;
  logic [16:0]        peak_next;
  logic [31:0]        samples_next;
  logic [17:0]        dev;
  logic [17:0]        dev_abs;
  logic [41:0]        energy_val;
  logic [32:0]        charge_val;
  logic [42:0]        eq;
  logic [32:0]        cq;

  // serial unit connections
  logic               mula_start, mulb_start;
  logic [MUL_W-1:0]   mula_mcand, mula_mplier;
  unit_stat_t         mula_stat, mulb_stat;
  logic [PROD_W-1:0]  mula_prod, mulb_prod;
  logic               diva_start, divb_start;
  logic [DVS_W-1:0]   diva_rem, divb_rem;
  logic [DVD_W-1:0]   diva_dvd, divb_dvd;
  logic [DVS_W-1:0]   diva_dvs;
  logic [DIV_CNT_W-1:0] diva_steps;
  unit_stat_t         diva_stat, divb_stat;
  logic [DVD_W-1:0]   diva_q, divb_q;
  logic [63:0]        emag, cmag;
  logic [63:0]        eadd, cadd;
  logic [20:0]        pq;

  // input unpacking and magnitudes
  assign dt_in     = s_axis_tdata[23:0];
  assign mv_in     = s_axis_tdata[40:24];
  assign ua_in     = s_axis_tdata[64:41];
  assign mv_in_mag = mv_in[16] ? (~mv_in + 17'd1) : mv_in;
  assign ua_in_mag = ua_in[23] ? (~ua_in + 24'd1) : ua_in;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // accumulator magnitudes and signed product terms
  assign emag = energy_acc[63] ? (~energy_acc + 64'd1) : energy_acc;
  assign cmag = charge_acc[63] ? (~charge_acc + 64'd1) : charge_acc;
  assign eadd = pneg ? (~{16'b0, mula_prod} + 64'd1) : {16'b0, mula_prod};
  assign cadd = ua[23] ? (~{16'b0, mulb_prod} + 64'd1) : {16'b0, mulb_prod};
  assign pq   = diva_q[20:0];

  // unit A multiplier: mV*uA first, then mW*us
  assign mula_start  = accept || ((state == S_DIVP) && diva_stat.done);
  assign mula_mcand  = (state == S_IDLE) ? {7'b0, mv_in_mag} : {3'b0, pq};
  assign mula_mplier = (state == S_IDLE) ? ua_in_mag : dt;

  // unit B multiplier: uA*us
  assign mulb_start = accept;

  // unit A divider: mW from the product, then uWh from the energy accumulator
  // the top dividend bits stand below the divisor, so they seed the remainder
  assign diva_start = ((state == S_MULP) && mula_stat.done) || (state == S_EACC);
  assign diva_rem   = (state == S_MULP) ? {13'b0, mula_prod[39:21]} : {11'b0, emag[63:43]};
  assign diva_dvd   = (state == S_MULP) ? {mula_prod[20:0], 43'b0} : {emag[42:0], 21'b0};
  assign diva_dvs   = (state == S_MULP) ? MW_DIV : UWH_DIV;
  assign diva_steps = (state == S_MULP) ? MW_STEPS : UWH_STEPS;

  // unit B divider: uAh from the charge accumulator
  assign divb_start = (state == S_DIVP) && diva_stat.done;
  assign divb_rem   = {1'b0, cmag[63:33]};
  assign divb_dvd   = {cmag[32:0], 31'b0};

  pem_mul u_mula (
    .clk    (clk),
    .rst    (rst),
    .start  (mula_start),
    .mcand  (mula_mcand),
    .mplier (mula_mplier),
    .stat   (mula_stat),
    .prod   (mula_prod)
  );

  pem_mul u_mulb (
    .clk    (clk),
    .rst    (rst),
    .start  (mulb_start),
    .mcand  (ua_in_mag),
    .mplier (dt_in),
    .stat   (mulb_stat),
    .prod   (mulb_prod)
  );

  pem_div u_diva (
    .clk      (clk),
    .rst      (rst),
    .start    (diva_start),
    .rem_init (diva_rem),
    .dividend (diva_dvd),
    .divisor  (diva_dvs),
    .steps    (diva_steps),
    .stat     (diva_stat),
    .quot     (diva_q)
  );

  pem_div u_divb (
    .clk      (clk),
    .rst      (rst),
    .start    (divb_start),
    .rem_init (divb_rem),
    .dividend (divb_dvd),
    .divisor  (UAH_DIV),
    .steps    (UAH_STEPS),
    .stat     (divb_stat),
    .quot     (divb_q)
  );

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_MULP;
      S_MULP: if (mula_stat.done) state_next = S_DIVP;
      S_DIVP: if (diva_stat.done) state_next = S_MULE;
      S_MULE: if (mula_stat.done) state_next = S_EACC;
      S_EACC: state_next = S_DIVE;
      S_DIVE: if (diva_stat.done) state_next = S_OUT;
      S_OUT:  if (!m_axis_tvalid || m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // min and max tracking, first sample loads all of them
  always_comb begin
    first          = (samples_seen == 32'd0);
    volt_low_next  = (first || (mv < volt_low))  ? mv : volt_low;
    volt_high_next = (first || (mv > volt_high)) ? mv : volt_high;
    amp_low_next   = (first || (ua < amp_low))   ? ua : amp_low;
    amp_high_next  = (first || (ua > amp_high))  ? ua : amp_high;
    watt_low_next  = (first || (mw < watt_low))  ? mw : watt_low;
    watt_high_next = (first || (mw > watt_high)) ? mw : watt_high;
    samples_next   = (samples_seen == 32'hFFFF_FFFF) ? samples_seen : samples_seen + 32'd1;
  end

  // deviation from the contract voltage
  always_comb begin
    dev     = {mv[16], mv} - {2'b00, contract};
    dev_abs = dev[17] ? (~dev + 18'd1) : dev;
    peak_next = deviation_peak;
    if ((contract != 16'd0) && (dev_abs[16:0] > deviation_peak)) begin
      peak_next = dev_abs[16:0];
    end
  end

  // signed quotients, energy clamped to its output range
  always_comb begin
    eq = diva_q[42:0];
    cq = divb_q[32:0];
    if (e_neg) begin
      energy_val = (eq > E_MAG_LIMIT) ? E_NEG_MIN : (~eq[41:0] + 42'd1);
    end else begin
      energy_val = (eq >= E_MAG_LIMIT) ? E_POS_MAX : eq[41:0];
    end
    charge_val = c_neg ? (~cq + 33'd1) : cq;
  end

  // control and statistics registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_axis_tvalid  <= 1'b0;
      contract       <= '0;
      volt_low       <= '0;
      volt_high      <= '0;
      amp_low        <= '0;
      amp_high       <= '0;
      watt_low       <= '0;
      watt_high      <= '0;
      energy_acc     <= '0;
      charge_acc     <= '0;
      deviation_peak <= '0;
      samples_seen   <= '0;
    end else begin
      state <= state_next;
      if ((state == S_MULP) && mula_stat.done) begin
        charge_acc <= charge_acc + cadd;
      end
      if ((state == S_MULE) && mula_stat.done) begin
        energy_acc <= energy_acc + eadd;
      end
      if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid  <= 1'b1;
        volt_low       <= volt_low_next;
        volt_high      <= volt_high_next;
        amp_low        <= amp_low_next;
        amp_high       <= amp_high_next;
        watt_low       <= watt_low_next;
        watt_high      <= watt_high_next;
        samples_seen   <= samples_next;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      // a contract write wins over the peak update
      if (cfg_we) begin
        contract       <= cfg_wdata;
        deviation_peak <= '0;
      end else if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
        deviation_peak <= peak_next;
      end
    end
  end

  // sample, intermediate and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      dt   <= dt_in;
      mv   <= mv_in;
      ua   <= ua_in;
      pneg <= mv_in[16] ^ ua_in[23];
    end
    if ((state == S_DIVP) && diva_stat.done) begin
      mw    <= pneg ? (~pq + 21'd1) : pq;
      c_neg <= charge_acc[63];
    end
    if (state == S_EACC) begin
      e_neg <= energy_acc[63];
    end
    if ((state == S_OUT) && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {3'b0, samples_next, peak_next, charge_val, energy_val,
                       watt_high_next, watt_low_next, amp_high_next, amp_low_next,
                       volt_high_next, volt_low_next, mw};
    end
  end

`ifndef SYNTHESIS
  // an input transfer always starts the first multiply
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_MULP))
    else $error("input transfer did not start the sequence");

  // once a sample is in, every minimum stays at or below its maximum
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (samples_seen != 32'd0) |->
      ((volt_low <= volt_high) && (amp_low <= amp_high) && (watt_low <= watt_high)))
    else $error("minimum above maximum");

  // a contract write clears the worst deviation
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (deviation_peak == 17'd0))
    else $error("worst deviation not cleared on contract write");

  // the charge division is finished before the energy division
  a_div_order: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIVE) && diva_stat.done) |-> !divb_stat.busy)
    else $error("charge quotient not ready at result time");

  // both multipliers finish together, so the charge term is ready with the power product
  a_mul_pair: assert property (@(posedge clk) disable iff (rst)
    ((state == S_MULP) && mula_stat.done) |-> mulb_stat.done)
    else $error("charge product not ready with power product");

  // a new result always carries a nonzero sample count
  a_count_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> (samples_seen != 32'd0))
    else $error("result issued with zero sample count");
`endif

endmodule

`default_nettype wire

// ===== hdl/pem_mul.sv =====
// bit-serial unsigned shift-add multiplier
`default_nettype none

module pem_mul import pem_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [MUL_W-1:0]  mcand,
  input  logic [MUL_W-1:0]  mplier,
  output unit_stat_t        stat,
  output logic [PROD_W-1:0] prod
);

  logic [MUL_W-1:0]     hi;
  logic [MUL_W-1:0]     lo;
  logic [MUL_W-1:0]     mc;
  logic [MUL_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [MUL_W:0]       sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, mc} : {(MUL_W + 1){1'b0}});

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial product shifts right one bit per step
  always_ff @(posedge clk) begin
    if (start) begin
      hi <= '0;
      lo <= mplier;
      mc <= mcand;
    end else if (busy) begin
      hi <= sum[MUL_W:1];
      lo <= {sum[0], lo[MUL_W-1:1]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign prod      = {hi, lo};

endmodule

`default_nettype wire

// ===== hdl/pem_div.sv =====
// bit-serial restoring divider by a constant divisor
`default_nettype none

module pem_div import pem_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DVS_W-1:0]     rem_init,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DVS_W-1:0]     divisor,
  input  logic [DIV_CNT_W-1:0] steps,
  output unit_stat_t           stat,
  output logic [DVD_W-1:0]     quot
);

  logic [DVS_W-1:0]     rem;
  logic [DVD_W-1:0]     sh;
  logic [DVS_W-1:0]     dv;
  logic [DIV_CNT_W-1:0] last;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 done;
  logic [DVS_W:0]       trial;
  logic [DVS_W:0]       diff;
  logic                 ge;

  // bring down the next dividend bit and try the subtraction
  assign trial = {rem, sh[DVD_W-1]};
  assign diff  = trial - {1'b0, dv};
  assign ge    = (trial >= {1'b0, dv});

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out at the top, quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= rem_init;
      sh   <= dividend;
      dv   <= divisor;
      last <= steps - 1'b1;
    end else if (busy) begin
      rem <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      sh  <= {sh[DVD_W-2:0], ge};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = sh;

endmodule

`default_nettype wire

// ===== dv/tb_power_energy_monitor.sv =====
// self-checking testbench for the power and energy monitor stream block
`timescale 1ns / 100ps

module tb_power_energy_monitor;

  // one output reading, field order as on m_axis_tdata from the highest bit down
  typedef struct packed {
    logic        [31:0] sample_count;
    logic        [16:0] worst_deviation;
    logic signed [32:0] charge_uah;
    logic signed [41:0] energy_uwh;
    logic signed [20:0] max_power;
    logic signed [20:0] min_power;
    logic signed [23:0] max_current;
    logic signed [23:0] min_current;
    logic signed [16:0] max_voltage;
    logic signed [16:0] min_voltage;
    logic signed [20:0] power_mw;
  } pem_reading_t;

  // one directed sample, with a hand-written reading where it is obvious
  typedef struct packed {
    logic        [23:0] elapsed_us;
    logic signed [16:0] voltage_mv;
    logic signed [23:0] current_ua;
    logic               has_reading;
    pem_reading_t       reading;
  } sample_row_t;

  localparam int DIRECTED_ROWS  = 14;
  localparam int PHASE_SAMPLES  = 306;
  localparam int HOLDOFF_CYCLES = 1000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int STALL_LIMIT    = 8000;
  localparam int REPORT_LIMIT   = 10;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // elapsed_us[23:0], voltage_mv[40:24], current_ua[64:41], zero pad [71:65]
  logic [71:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // power_mw, min/max voltage, min/max current, min/max power, energy_uwh,
  // charge_uah, worst_deviation, sample_count, zero pad
  logic [271:0] m_axis_tdata;
  logic         cfg_we;
  logic [15:0]  cfg_wdata;

  power_energy_monitor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // clock, 12 ns period
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // monitor state mirrored by the predictor
  logic [15:0]  agreed_mv;
  longint       volt_min, volt_max, amp_min, amp_max, watt_min, watt_max;
  logic [63:0]  energy_sum;
  logic [63:0]  charge_sum;
  longint       dev_peak;
  logic [31:0]  samples_taken;

  pem_reading_t expected_readings[$];
  int           mismatches;
  int           readings_seen;
  int           idle_pct;
  logic         holding;
  int           quiet_cycles;
  event         holdoff_go;
  sample_row_t  directed_rows [DIRECTED_ROWS];

  // expected reading for one sample, advancing the mirrored state
  function automatic pem_reading_t monitor_sample(logic [23:0] dt,
                                                  logic signed [16:0] mv,
                                                  logic signed [23:0] ua);
    pem_reading_t r;
    longint       mv_l;
    longint       ua_l;
    longint       mw;
    longint       dt_l;
    longint       dev;
    longint       energy;
    longint       charge;
    logic [63:0]  mag;
    logic [63:0]  quot;
    mv_l = mv;
    ua_l = ua;
    dt_l = longint'(dt);
    mw   = (mv_l * ua_l) / 64'sd1000000;

    // first sample loads the extremes, later ones widen them
    if (samples_taken == 32'd0) begin
      volt_min = mv_l;
      volt_max = mv_l;
      amp_min  = ua_l;
      amp_max  = ua_l;
      watt_min = mw;
      watt_max = mw;
    end else begin
      if (mv_l < volt_min) volt_min = mv_l;
      if (mv_l > volt_max) volt_max = mv_l;
      if (ua_l < amp_min) amp_min = ua_l;
      if (ua_l > amp_max) amp_max = ua_l;
      if (mw < watt_min) watt_min = mw;
      if (mw > watt_max) watt_max = mw;
    end
    if (samples_taken != 32'hFFFF_FFFF) samples_taken = samples_taken + 32'd1;

    // wrapping integrators
    energy_sum = energy_sum + 64'(mw * dt_l);
    charge_sum = charge_sum + 64'(ua_l * dt_l);

    // energy in uWh, truncated toward zero and clamped to 42 bits
    mag  = energy_sum[63] ? (~energy_sum + 64'd1) : energy_sum;
    quot = mag / 64'd3600000;
    if (energy_sum[63])
      energy = (quot > 64'h200_0000_0000) ? -(64'sd1 <<< 41) : -longint'(quot);
    else
      energy = (quot > 64'h1FF_FFFF_FFFF) ? ((64'sd1 <<< 41) - 1) : longint'(quot);

    // charge in uAh always fits
    mag    = charge_sum[63] ? (~charge_sum + 64'd1) : charge_sum;
    quot   = mag / 64'd3600000000;
    charge = charge_sum[63] ? -longint'(quot) : longint'(quot);

    // deviation from the contract voltage, frozen while the contract is zero
    if (agreed_mv != 16'd0) begin
      dev = mv_l - longint'(agreed_mv);
      if (dev < 0) dev = -dev;
      if (dev > dev_peak) dev_peak = dev;
    end

    r.power_mw        = 21'(mw);
    r.min_voltage     = 17'(volt_min);
    r.max_voltage     = 17'(volt_max);
    r.min_current     = 24'(amp_min);
    r.max_current     = 24'(amp_max);
    r.min_power       = 21'(watt_min);
    r.max_power       = 21'(watt_max);
    r.energy_uwh      = 42'(energy);
    r.charge_uah      = 33'(charge);
    r.worst_deviation = 17'(dev_peak);
    r.sample_count    = samples_taken;
    return r;
  endfunction

  function automatic void field_report(string field_name, longint want, longint got);
    if (want != got) $display("  %s: expected %0d, got %0d", field_name, want, got);
  endfunction

  // compare one transfer on the output with the oldest expected reading
  task automatic check_reading(pem_reading_t got);
    pem_reading_t want;
    if (expected_readings.size() == 0) begin
      if (mismatches < REPORT_LIMIT)
        $display("unexpected reading %0d at %0t: %h", readings_seen, $realtime, got);
      mismatches++;
    end else begin
      want = expected_readings.pop_front();
      if (want != got) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("reading %0d mismatch at %0t", readings_seen, $realtime);
          field_report("power_mw", want.power_mw, got.power_mw);
          field_report("min_voltage", want.min_voltage, got.min_voltage);
          field_report("max_voltage", want.max_voltage, got.max_voltage);
          field_report("min_current", want.min_current, got.min_current);
          field_report("max_current", want.max_current, got.max_current);
          field_report("min_power", want.min_power, got.min_power);
          field_report("max_power", want.max_power, got.max_power);
          field_report("energy_uwh", want.energy_uwh, got.energy_uwh);
          field_report("charge_uah", want.charge_uah, got.charge_uah);
          field_report("worst_deviation", want.worst_deviation, got.worst_deviation);
          field_report("sample_count", want.sample_count, got.sample_count);
        end
        mismatches++;
      end
    end
    readings_seen++;
  endtask

  // output side: check each transfer, then choose the next tready
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_reading(pem_reading_t'(m_axis_tdata[268:0]));
      m_axis_tready <= !holding && ($urandom_range(99) >= idle_pct);
    end
  end

  // long receiver hold-off so the block fills up and stalls its input
  initial begin
    holding = 1'b0;
    @(holdoff_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLDOFF_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one sample, with a random gap ahead of it
  task automatic send_sample(logic [23:0] dt, logic signed [16:0] mv,
                             logic signed [23:0] ua, logic has_reading,
                             pem_reading_t reading);
    pem_reading_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ua, mv, dt};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predicted = monitor_sample(dt, mv, ua);
    expected_readings.push_back(has_reading ? reading : predicted);
  endtask

  // random sample: mostly voltages near the contract, short intervals
  task automatic send_random_sample();
    logic [23:0]        dt;
    logic signed [16:0] mv;
    logic signed [23:0] ua;
    int                 pick;
    int                 offset;
    pick = $urandom_range(99);
    if (pick < 10) dt = 24'($urandom);
    else if (pick < 14) dt = 24'hFF_FFFF;
    else if (pick < 17) dt = 24'd0;
    else dt = 24'($urandom_range(1, 5000));
    pick = $urandom_range(99);
    offset = int'($urandom_range(4000)) - 2000;
    if (pick < 55) mv = 17'(int'(agreed_mv) + offset);
    else if (pick < 60) mv = (pick & 1) ? 17'sh0FFFF : 17'sh10000;
    else mv = 17'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) ua = 24'(int'($urandom_range(3000000)) - 1000000);
    else if (pick < 45) ua = (pick & 1) ? 24'sh7FFFFF : 24'sh800000;
    else ua = 24'($urandom);
    send_sample(dt, mv, ua, 1'b0, '0);
  endtask

  // contract register write, only once every reading is back
  task automatic write_contract(logic [15:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    agreed_mv   = value;
    dev_peak    = 0;
  endtask

  task automatic run_phase(logic [15:0] contract, int pct, logic with_holdoff);
    write_contract(contract);
    idle_pct = pct;
    for (int i = 0; i < PHASE_SAMPLES; i++) begin
      if (with_holdoff && i == 40) -> holdoff_go;
      send_random_sample();
    end
  endtask

  // directed samples; the first three readings are written out by hand
  initial begin
    directed_rows[0]  = '{24'd0, 17'sd0, 24'sd0, 1'b1,
                          '{32'd1, 17'd0, 33'sd0, 42'sd0, 21'sd0, 21'sd0,
                            24'sd0, 24'sd0, 17'sd0, 17'sd0, 21'sd0}};
    directed_rows[1]  = '{24'd0, -17'sd65536, -24'sd8388608, 1'b1,
                          '{32'd2, 17'd0, 33'sd0, 42'sd0, 21'sd549755, 21'sd0,
                            24'sd0, -24'sd8388608, 17'sd0, -17'sd65536, 21'sd549755}};
    directed_rows[2]  = '{24'd0, 17'sd65535, 24'sd8388607, 1'b1,
                          '{32'd3, 17'd0, 33'sd0, 42'sd0, 21'sd549755, 21'sd0,
                            24'sd8388607, -24'sd8388608, 17'sd65535, -17'sd65536,
                            21'sd549747}};
    directed_rows[3]  = '{24'hFF_FFFF, 17'sd65535, 24'sd8388607, 1'b0, '0};
    directed_rows[4]  = '{24'hFF_FFFF, -17'sd65536, 24'sd8388607, 1'b0, '0};
    directed_rows[5]  = '{24'd1, -17'sd1, 24'sd1, 1'b0, '0};
    directed_rows[6]  = '{24'd1000, 17'sd1000, -24'sd1500000, 1'b0, '0};
    directed_rows[7]  = '{24'd1, 17'sd1, -24'sd1, 1'b0, '0};
    directed_rows[8]  = '{24'd123456, 17'sd5000, 24'sd3000000, 1'b0, '0};
    directed_rows[9]  = '{24'hFF_FFFF, 17'sd0, -24'sd8388608, 1'b0, '0};
    directed_rows[10] = '{24'd800000, -17'sd20000, -24'sd2000000, 1'b0, '0};
    directed_rows[11] = '{24'h80_0000, 17'sh0AAAA, 24'sh555555, 1'b0, '0};
    directed_rows[12] = '{24'h55_5555, 17'sh15555, 24'shAAAAAA, 1'b0, '0};
    directed_rows[13] = '{24'hAA_AAAA, 17'sd12000, 24'sd250000, 1'b0, '0};
  end

  // reset, directed part, random phases, drain and verdict
  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    mismatches    = 0;
    readings_seen = 0;
    idle_pct      = 27;
    agreed_mv     = '0;
    volt_min = 0; volt_max = 0; amp_min = 0; amp_max = 0; watt_min = 0; watt_max = 0;
    energy_sum    = '0;
    charge_sum    = '0;
    dev_peak      = 0;
    samples_taken = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // contract still zero from reset: deviation stays at zero
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_sample(directed_rows[i].elapsed_us, directed_rows[i].voltage_mv,
                  directed_rows[i].current_ua, directed_rows[i].has_reading,
                  directed_rows[i].reading);

    run_phase(16'd65535, 27, 1'b1);
    run_phase(16'd1, 27, 1'b0);
    run_phase(16'd5000, 27, 1'b0);
    // writing zero clears the peak and freezes it
    run_phase(16'd0, 27, 1'b0);
    // no idling on either side
    run_phase(16'd20000, 0, 1'b0);
    run_phase(16'd12000, 27, 1'b0);

    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== power_energy_monitor.f =====
hdl/pem_pkg.sv
hdl/pem_mul.sv
hdl/pem_div.sv
hdl/power_energy_monitor.sv
dv/tb_power_energy_monitor.sv
